// File: design/pol_pkg.sv
`default_nettype none
package pol_pkg;

	// list sizing
	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;

	// field widths of the request and result
	localparam int FUNC_W      = 2;
	localparam int POS_W       = 5;
	localparam int VALUE_IN_W  = 32;
	localparam int VALUE_OUT_W = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 5;

	// internal widths
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// operation codes
	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;
	localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]      idx_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic   ins;
		logic   del;
		idx_t   pos;
		value_t value;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: design/pol_req_if.sv
`default_nettype none
interface pol_req_if;
	logic                            valid;
	logic                            ready;
	logic [pol_pkg::FUNC_W-1:0]      func;
	logic [pol_pkg::POS_W-1:0]       position;
	logic [pol_pkg::VALUE_IN_W-1:0]  value_in;

	modport source (output valid, output func, output position, output value_in,
		input ready);
	modport sink (input valid, input func, input position, input value_in,
		output ready);
endinterface
`default_nettype wire

// File: design/pol_rsp_if.sv
`default_nettype none
interface pol_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [pol_pkg::VALUE_OUT_W-1:0] value_out;
	logic [pol_pkg::STATUS_W-1:0]    status;
	logic [pol_pkg::COUNT_W-1:0]     count;

	modport source (output valid, output value_out, output status, output count,
		input ready);
	modport sink (input valid, input value_out, input status, input count,
		output ready);
endinterface
`default_nettype wire

// File: design/positional_ordered_list_top.sv
`default_nettype none
// Positional ordered list: up to CAPACITY values kept in order, addressed by
// position from zero. Requests arrive on req (func, position, value_in);
// each yields one result on rsp (value_out, status, count).
// func: insert before position, get at position, delete at position, clear.
// Status reports ok, position out of range, or list full; errors leave the
// list unchanged and return value_out zero.
// The list lives in a row of cells; an insert or delete moves every cell at
// once, so any request finishes in the cycle it is accepted.
// The result is registered and valid in the cycle after acceptance.
// Throughput: one request per cycle unless a stalled result is held.
// req.ready is high while the result register is empty or being drained, so
// a stalled receiver holds the result and blocks only the next request.
// Reset empties the list (count zero) and drops any pending result; cells
// are not cleared, stale entries lie beyond the count and are never read.
module positional_ordered_list_top (
	input  wire logic clk,
	input  wire logic arst_n,
	pol_req_if.sink   req,
	pol_rsp_if.source rsp
);

	localparam int CAP = pol_pkg::CAPACITY;

	logic                           accept;
	logic [pol_pkg::CNT_W-1:0]      cnt_q;
	logic [pol_pkg::CNT_W-1:0]      cnt_d;
	pol_pkg::idx_t                  pos;
	pol_pkg::idx_t                  cnt_ext;
	pol_pkg::cell_ctl_t             ctl;
	logic [pol_pkg::STATUS_W-1:0]   status_d;
	pol_pkg::value_t                rd_value;
	pol_pkg::value_t                value_d;
	pol_pkg::value_t                entry [CAP];
	pol_pkg::value_t                sel [CAP];

	logic                           rsp_valid_q;
	logic [pol_pkg::VALUE_OUT_W-1:0] value_out_q;
	logic [pol_pkg::STATUS_W-1:0]   status_q;
	logic [pol_pkg::COUNT_W-1:0]    count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos       = pol_pkg::IDX_W'(req.position);
	assign cnt_ext   = pol_pkg::IDX_W'(cnt_q);

	// OR the addressed cell onto the read bus
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAP; i++) begin
			rd_value = rd_value | sel[i];
		end
	end

	// decode the request
	always_comb begin
		status_d  = pol_pkg::ST_OK;
		value_d   = '0;
		cnt_d     = cnt_q;
		ctl.ins   = 1'b0;
		ctl.del   = 1'b0;
		ctl.pos   = pos;
		ctl.value = pol_pkg::VALUE_BITS'(req.value_in);
		unique case (req.func)
			pol_pkg::OP_INSERT: begin
				if (pos > cnt_ext) begin
					status_d = pol_pkg::ST_RANGE;
				end else if (cnt_q == pol_pkg::CNT_W'(CAP)) begin
					status_d = pol_pkg::ST_FULL;
				end else begin
					ctl.ins = accept;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			pol_pkg::OP_GET: begin
				if (pos >= cnt_ext) begin
					status_d = pol_pkg::ST_RANGE;
				end else begin
					value_d = rd_value;
				end
			end
			pol_pkg::OP_DELETE: begin
				if (pos >= cnt_ext) begin
					status_d = pol_pkg::ST_RANGE;
				end else begin
					value_d = rd_value;
					ctl.del = accept;
					cnt_d   = cnt_q - 1'b1;
				end
			end
			pol_pkg::OP_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				status_d = pol_pkg::ST_OK;
			end
		endcase
	end

	// row of cells, each fed by its neighbors
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		pol_pkg::value_t left;
		pol_pkg::value_t right;
		if (i == 0) begin : g_first
			assign left = ctl.value;
		end else begin : g_mid_l
			assign left = entry[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = entry[i+1];
		end
		pol_cell u_cell (
			.clk   (clk),
			.idx   (pol_pkg::IDX_W'(i)),
			.ctl   (ctl),
			.left  (left),
			.right (right),
			.entry (entry[i]),
			.sel   (sel[i])
		);
	end

	// update the count on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= pol_pkg::VALUE_OUT_W'(value_d);
			status_q    <= status_d;
			count_q     <= pol_pkg::COUNT_W'(cnt_d);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = value_out_q;
	assign rsp.status    = status_q;
	assign rsp.count     = count_q;

endmodule
`default_nettype wire

// File: design/pol_cell.sv
`default_nettype none
module pol_cell (
	input  wire logic               clk,
	input  wire pol_pkg::idx_t      idx,
	input  wire pol_pkg::cell_ctl_t ctl,
	input  wire pol_pkg::value_t    left,
	input  wire pol_pkg::value_t    right,
	output pol_pkg::value_t         entry,
	output pol_pkg::value_t         sel
);

	pol_pkg::value_t entry_q;

	// shift up on insert, shift down on delete, otherwise hold
	always_ff @(posedge clk) begin
		if (ctl.ins && idx > ctl.pos) begin
			entry_q <= left;
		end else if (ctl.ins && idx == ctl.pos) begin
			entry_q <= ctl.value;
		end else if (ctl.del && idx >= ctl.pos) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	// drive the read bus only when this cell is addressed
	assign sel = (idx == ctl.pos) ? entry_q : '0;

endmodule
`default_nettype wire

// File: design/pol_checker.sv
`default_nettype none
module pol_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            rsp_valid,
	input wire logic                            rsp_ready,
	input wire logic [pol_pkg::VALUE_OUT_W-1:0] value_out,
	input wire logic [pol_pkg::STATUS_W-1:0]    status,
	input wire logic [pol_pkg::COUNT_W-1:0]     count
);

	// a stalled result stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(value_out) && $stable(status) && $stable(count))
		else $error("result changed while stalled");

	// length never exceeds the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= pol_pkg::COUNT_W'(pol_pkg::CAPACITY))
		else $error("count beyond capacity");

	// full is reported only on a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == pol_pkg::ST_FULL
		|-> count == pol_pkg::COUNT_W'(pol_pkg::CAPACITY))
		else $error("full status with room left");

	// errors return no value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == pol_pkg::ST_RANGE || status == pol_pkg::ST_FULL)
		|-> value_out == '0)
		else $error("error result carries a value");

endmodule

bind positional_ordered_list_top pol_checker u_pol_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.value_out (rsp.value_out),
	.status    (rsp.status),
	.count     (rsp.count)
);
`default_nettype wire
